### hdl/wmb_pkg.sv
//------------------------------------------------------------------------------
// wmb_pkg
// Shared types and constants of the weighted map binner: queue entry layout,
// fixed-point widths, saturation limits and transaction mode codes.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wmb_pkg;

   // fixed-point widths of the bin sums
   localparam int NUM_W = 48;
   localparam int DEN_W = 40;

   // clamped product is held in [-2^48, 2^48]
   localparam int PROD_W = 50;
   // wide enough for any sample times weight product
   localparam int WIDE_W = 66;

   // queue entry field widths, sized for the largest configuration
   localparam int ADDR_FIELD_W   = 26;
   localparam int WEIGHT_FIELD_W = 32;

   // queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // configuration register
   localparam int            CFG_W     = 7;
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   // transaction modes
   localparam logic MODE_ACC  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   // saturation limits
   localparam logic [NUM_W-1:0] NUM_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [NUM_W-1:0] NUM_MIN = 48'h8000_0000_0000;
   localparam logic [DEN_W-1:0] DEN_MAX = 40'hFF_FFFF_FFFF;

   // product clamp bounds
   localparam logic signed [WIDE_W-1:0] CLAMP_HI = 66'sd281474976710656;
   localparam logic signed [WIDE_W-1:0] CLAMP_LO = -66'sd281474976710656;

   // one classified transaction on its way to the back end
   typedef struct packed {
      logic                             mode;
      logic                             ok;
      logic [ADDR_FIELD_W-1:0]          addr;
      logic signed [PROD_W-1:0]         prod;
      logic [WEIGHT_FIELD_W-1:0]        weight;
   } wmb_entry_type;

endpackage

`default_nettype wire

### hdl/wmb_if.sv
//------------------------------------------------------------------------------
// wmb channel interfaces
// Valid/ready channels of the weighted map binner: request, response and
// configuration write.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wmb_req_if #(
   parameter int SAMPLE_BITS = 16,
   parameter int WEIGHT_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [9:0]                    pixel_index;
   logic [5:0]                    channel;
   logic signed [SAMPLE_BITS-1:0] sample_value;
   logic [WEIGHT_BITS-1:0]        weight;

   modport source (output valid, mode, pixel_index, channel, sample_value, weight,
                   input ready);
   modport sink   (input valid, mode, pixel_index, channel, sample_value, weight,
                   output ready);
endinterface

interface wmb_rsp_if ();
   logic               valid;
   logic               ready;
   logic signed [47:0] bin_numerator;
   logic [39:0]        bin_denominator;

   modport source (output valid, bin_numerator, bin_denominator, input ready);
   modport sink   (input valid, bin_numerator, bin_denominator, output ready);
endinterface

interface wmb_csr_if ();
   logic       valid;
   logic       ready;
   logic [6:0] channels_in_use;

   modport source (output valid, channels_in_use, input ready);
   modport sink   (input valid, channels_in_use, output ready);
endinterface

`default_nettype wire

### hdl/wmb_front.sv
//------------------------------------------------------------------------------
// wmb_front
// Accepts request transactions, checks the bin range, forms the bin address
// and the sample times weight product, and pushes the result into the queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmb_front #(
   parameter int NUM_PIXELS   = 1024,
   parameter int NUM_CHANNELS = 64,
   parameter int SAMPLE_BITS  = 16,
   parameter int WEIGHT_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   wmb_req_if.sink                            req,
   input  wire logic [wmb_pkg::CFG_W-1:0]     channels_in_use,
   input  wire logic                          clear_busy,
   input  wire logic                          fifo_full,
   output logic                               push,
   output wmb_pkg::wmb_entry_type             push_entry
);

   localparam int PW = SAMPLE_BITS + WEIGHT_BITS + 1;
   localparam int AW = wmb_pkg::ADDR_FIELD_W;

   logic                          stage_valid_ff, stage_valid_in;
   logic                          stage_mode_ff;
   logic                          stage_ok_ff;
   logic [AW-1:0]                 stage_addr_ff;
   logic signed [PW-1:0]          stage_prod_ff;
   logic [WEIGHT_BITS-1:0]        stage_weight_ff;

   logic                          accept;
   logic                          pix_ok, ch_ok;
   logic [AW-1:0]                 addr_calc;
   logic signed [PW-1:0]          prod_calc;
   logic signed [wmb_pkg::WIDE_W-1:0] prod_wide;
   logic signed [wmb_pkg::WIDE_W-1:0] prod_clamped;

   // take a new transaction when no clearing pass runs and the stage is free or drains this cycle
   assign push      = stage_valid_ff && !fifo_full;
   assign req.ready = !clear_busy && (!stage_valid_ff || !fifo_full);
   assign accept    = req.valid && req.ready;

   // bin range check and address
   assign pix_ok    = 32'(req.pixel_index) < NUM_PIXELS;
   assign ch_ok     = ({1'b0, req.channel} < channels_in_use) &&
                      (32'(req.channel) < NUM_CHANNELS);
   assign addr_calc = AW'(req.pixel_index) * AW'(NUM_CHANNELS) + AW'(req.channel);

   // sample times zero-extended weight
   assign prod_calc = PW'(req.sample_value) * PW'($signed({1'b0, req.weight}));

   // stage valid
   assign stage_valid_in = accept || (stage_valid_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_mode_ff   <= req.mode;
         stage_ok_ff     <= pix_ok && ch_ok;
         stage_addr_ff   <= addr_calc;
         stage_prod_ff   <= prod_calc;
         stage_weight_ff <= req.weight;
      end
   end

   // clamp product well outside the numerator range
   always_comb begin
      prod_wide = wmb_pkg::WIDE_W'(stage_prod_ff);
      if (prod_wide > wmb_pkg::CLAMP_HI) begin
         prod_clamped = wmb_pkg::CLAMP_HI;
      end else if (prod_wide < wmb_pkg::CLAMP_LO) begin
         prod_clamped = wmb_pkg::CLAMP_LO;
      end else begin
         prod_clamped = prod_wide;
      end
   end

   // queue entry
   always_comb begin
      push_entry.mode   = stage_mode_ff;
      push_entry.ok     = stage_ok_ff;
      push_entry.addr   = stage_addr_ff;
      push_entry.prod   = prod_clamped[wmb_pkg::PROD_W-1:0];
      push_entry.weight = wmb_pkg::WEIGHT_FIELD_W'(stage_weight_ff);
   end

endmodule

`default_nettype wire

### hdl/wmb_fifo.sv
//------------------------------------------------------------------------------
// wmb_fifo
// Short queue of classified transactions between the front and back ends.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmb_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire wmb_pkg::wmb_entry_type push_entry,
   input  wire logic                   pop,
   output wmb_pkg::wmb_entry_type      head_entry,
   output logic                        full,
   output logic                        empty
);

   wmb_pkg::wmb_entry_type               entry_ff [wmb_pkg::FIFO_DEPTH];
   logic [wmb_pkg::FIFO_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [wmb_pkg::FIFO_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [wmb_pkg::FIFO_CNT_W-1:0]       count_ff, count_in;
   logic                                 do_push, do_pop;

   assign full       = count_ff == wmb_pkg::FIFO_CNT_W'(wmb_pkg::FIFO_DEPTH);
   assign empty      = count_ff == '0;
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### hdl/wmb_back.sv
//------------------------------------------------------------------------------
// wmb_back
// Bin memory and its sequencer: clears the bins after reset, then reads a bin
// for each queued transaction and either writes back the saturated sums or
// returns them on the response channel.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmb_back #(
   parameter int NUM_PIXELS   = 1024,
   parameter int NUM_CHANNELS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fifo_empty,
   input  wire wmb_pkg::wmb_entry_type head_entry,
   output logic                       pop,
   output logic                       clear_busy,
   wmb_rsp_if.source                  rsp
);

   localparam int NUM_BINS = NUM_PIXELS * NUM_CHANNELS;
   localparam int ADDR_W   = $clog2(NUM_BINS);
   localparam int NW       = wmb_pkg::NUM_W;
   localparam int DW       = wmb_pkg::DEN_W;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [NW-1:0]            numer_mem [NUM_BINS];
   logic [DW-1:0]            denom_mem [NUM_BINS];

   logic [1:0]               state_ff, state_in;
   logic [ADDR_W-1:0]        clear_cnt_ff, clear_cnt_in;
   wmb_pkg::wmb_entry_type   cur_ff;
   logic [NW-1:0]            rd_num_ff;
   logic [DW-1:0]            rd_den_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]            rsp_num_ff;
   logic [DW-1:0]            rsp_den_ff;

   logic                     rsp_free, rsp_load;
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr;
   logic [NW-1:0]            wr_num;
   logic [DW-1:0]            wr_den;
   logic [NW+2:0]            num_sum;
   logic [DW:0]              den_sum;
   logic [NW-1:0]            num_sat;
   logic [DW-1:0]            den_sat;
   logic                     last_clear;

   assign clear_busy = state_ff == ST_CLEAR;
   assign last_clear = clear_cnt_ff == ADDR_W'(NUM_BINS - 1);
   assign pop        = (state_ff == ST_IDLE) && !fifo_empty;
   assign rsp_free   = !rsp_valid_ff || rsp.ready;
   assign rsp_load   = (state_ff == ST_EXEC) && (cur_ff.mode == wmb_pkg::MODE_READ) && rsp_free;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (last_clear) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cur_ff.mode == wmb_pkg::MODE_ACC || rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // saturating numerator and denominator update
   always_comb begin
      num_sum = {{3{rd_num_ff[NW-1]}}, rd_num_ff} + {cur_ff.prod[wmb_pkg::PROD_W-1], cur_ff.prod};
      if (!num_sum[NW+2] && (num_sum[NW+2:NW-1] != 4'h0)) begin
         num_sat = wmb_pkg::NUM_MAX;
      end else if (num_sum[NW+2] && (num_sum[NW+2:NW-1] != 4'hF)) begin
         num_sat = wmb_pkg::NUM_MIN;
      end else begin
         num_sat = num_sum[NW-1:0];
      end
      den_sum = {1'b0, rd_den_ff} + (DW+1)'(cur_ff.weight);
      den_sat = den_sum[DW] ? wmb_pkg::DEN_MAX : den_sum[DW-1:0];
   end

   // memory write port: clearing pass or accumulate write-back
   always_comb begin
      mem_we    = clear_busy ||
                  ((state_ff == ST_EXEC) && (cur_ff.mode == wmb_pkg::MODE_ACC) && cur_ff.ok);
      mem_waddr = clear_busy ? clear_cnt_ff : ADDR_W'(cur_ff.addr);
      wr_num    = clear_busy ? '0 : num_sat;
      wr_den    = clear_busy ? '0 : den_sat;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         numer_mem[mem_waddr] <= wr_num;
         denom_mem[mem_waddr] <= wr_den;
      end
   end

   // memory read port and current transaction
   always_ff @(posedge clock) begin
      if (pop) begin
         rd_num_ff <= numer_mem[ADDR_W'(head_entry.addr)];
         rd_den_ff <= denom_mem[ADDR_W'(head_entry.addr)];
         cur_ff    <= head_entry;
      end
   end

   // response register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_num_ff <= cur_ff.ok ? rd_num_ff : '0;
         rsp_den_ff <= cur_ff.ok ? rd_den_ff : '0;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.bin_numerator   = rsp_num_ff;
   assign rsp.bin_denominator = rsp_den_ff;

endmodule

`default_nettype wire

### hdl/weighted_map_binner.sv
//------------------------------------------------------------------------------
// weighted_map_binner
// Weighted histogram accumulation of streamed samples into per-pixel,
// per-channel map bins with saturating numerator and denominator sums.
//------------------------------------------------------------------------------
// After reset the block clears all NUM_PIXELS*NUM_CHANNELS bins (65536 at
// the defaults), one per cycle; req_port.ready stays low until that pass is
// done. Afterwards the front end takes one transaction per cycle, while the
// queue has room, into a four-entry queue, and the back end handles each by a
// registered read of the bin memories, then an add and write back or a load of
// the response register, and finishes one before it pops the next; a read
// transaction also waits while the response register is still held by the
// sink. Accumulate transactions produce no response, a read produces exactly
// one; items naming no bin are dropped or read back as zero.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module weighted_map_binner #(
   parameter int NUM_PIXELS   = 1024,
   parameter int NUM_CHANNELS = 64,
   parameter int SAMPLE_BITS  = 16,
   parameter int WEIGHT_BITS  = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   wmb_req_if.sink     req_port,
   wmb_rsp_if.source   rsp_port,
   wmb_csr_if.sink     csr_port
);

   logic [wmb_pkg::CFG_W-1:0]  channels_in_use_ff, channels_in_use_in;
   logic                       clear_busy;
   logic                       push, pop;
   logic                       fifo_full, fifo_empty;
   wmb_pkg::wmb_entry_type     push_entry;
   wmb_pkg::wmb_entry_type     head_entry;

   // configuration register
   assign csr_port.ready     = 1'b1;
   assign channels_in_use_in = (csr_port.valid && csr_port.ready) ?
                               csr_port.channels_in_use : channels_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         channels_in_use_ff <= wmb_pkg::CFG_RESET;
      end else begin
         channels_in_use_ff <= channels_in_use_in;
      end
   end

   // classify and form products
   wmb_front #(
      .NUM_PIXELS   (NUM_PIXELS),
      .NUM_CHANNELS (NUM_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req             (req_port),
      .channels_in_use (channels_in_use_ff),
      .clear_busy      (clear_busy),
      .fifo_full       (fifo_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   // decoupling queue
   wmb_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .full       (fifo_full),
      .empty      (fifo_empty)
   );

   // bin memory and read-modify-write
   wmb_back #(
      .NUM_PIXELS   (NUM_PIXELS),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .head_entry (head_entry),
      .pop        (pop),
      .clear_busy (clear_busy),
      .rsp        (rsp_port)
   );

`ifndef SYNTH
   // no request taken while the bins are being cleared
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_port.ready)
      else $error("request accepted during clearing pass");

   // no response can exist before the clearing pass ends
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !rsp_port.valid)
      else $error("response during clearing pass");

   // queue state is consistent
   a_fifo_flags: assert property (@(posedge clock) disable iff (reset)
      !(fifo_full && fifo_empty))
      else $error("queue both full and empty");

   // back end pops only queued transactions
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_empty && !clear_busy)
      else $error("pop from empty queue or during clearing");
`endif

endmodule

`default_nettype wire
